FILE: rtl/gal_pkg.sv
// Package with the item types and fixed field widths of the GCD and LCM unit.
`timescale 1ns / 1ps
`default_nettype none

package gal_pkg;

  // Fixed widths of the item fields.
  localparam int FIELD_W    = 32;
  localparam int DIVISOR_W  = 31;
  localparam int MULTIPLE_W = 62;

  // One request item: two signed operands.
  typedef struct packed {
    logic signed [FIELD_W-1:0] first_value;
    logic signed [FIELD_W-1:0] second_value;
  } gal_req_t;

  // One response item: flag, greatest common divisor and least common multiple.
  typedef struct packed {
    logic                  valid_res;
    logic [DIVISOR_W-1:0]  divisor;
    logic [MULTIPLE_W-1:0] multiple;
  } gal_rsp_t;

endpackage

`default_nettype wire

FILE: rtl/gal_front.sv
// Front end: accepts request items, extracts and classifies the operands.
`timescale 1ns / 1ps
`default_nettype none

module gal_front import gal_pkg::*; #(
  parameter int OPERAND_WIDTH = 32
) (
  input  wire logic                       req_valid,
  output logic                            req_stall,
  input  wire gal_req_t                   req,
  input  wire logic                       full,
  output logic                            push,
  output logic [2*OPERAND_WIDTH-2:0]      push_data
);

  localparam int MW = OPERAND_WIDTH - 1;

  logic [OPERAND_WIDTH-1:0] first_op;
  logic [OPERAND_WIDTH-1:0] second_op;
  logic                     first_pos;
  logic                     second_pos;

  // Each operand is the low bits of its field; it counts only when strictly positive.
  always_comb begin
    first_op   = req.first_value[OPERAND_WIDTH-1:0];
    second_op  = req.second_value[OPERAND_WIDTH-1:0];
    first_pos  = !first_op[OPERAND_WIDTH-1] && (first_op != '0);
    second_pos = !second_op[OPERAND_WIDTH-1] && (second_op != '0);
  end

  // An item is taken whenever the queue has room.
  assign req_stall = full;
  assign push      = req_valid && !full;
  assign push_data = {first_pos && second_pos, first_op[MW-1:0], second_op[MW-1:0]};

endmodule

`default_nettype wire

FILE: rtl/gal_fifo.sv
// Short register queue that decouples the front end from the arithmetic core.
`timescale 1ns / 1ps
`default_nettype none

module gal_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      pop_data,
  output logic                  empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entries [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;

  assign full     = (count == CW'(DEPTH));
  assign empty    = (count == '0);
  assign pop_data = entries[rd_ptr];

  // Storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/gal_core.sv
// Arithmetic core: binary GCD, restoring division and one multiply per item.
`timescale 1ns / 1ps
`default_nettype none

module gal_core import gal_pkg::*; #(
  parameter int OPERAND_WIDTH = 32
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic [2*OPERAND_WIDTH-2:0] pop_data,
  input  wire logic                   empty,
  output logic                        pop,
  output logic                        rsp_valid,
  input  wire logic                   rsp_stall,
  output gal_rsp_t                    rsp
);

  localparam int MW = OPERAND_WIDTH - 1;
  localparam int KW = $clog2(MW + 1);

  typedef enum logic [1:0] {
    IDLE,
    GCD,
    DIV,
    WRITE
  } state_t;

  state_t          state;
  logic            ok;
  logic [MW-1:0]   a;
  logic [MW-1:0]   b;
  logic [MW-1:0]   quo;
  logic [MW-1:0]   b0;
  logic [MW-1:0]   g;
  logic [MW-1:0]   rem;
  logic [KW-1:0]   k;
  logic [KW-1:0]   cnt;

  logic [MW:0]     trial;
  logic            fits;
  logic [2*MW-1:0] prod;
  logic            slot_free;

  // Restoring division step: bring down the next dividend bit and try g.
  always_comb begin
    trial = {rem, quo[MW-1]};
    fits  = (trial >= {1'b0, g});
  end

  // Quotient times the second operand gives the multiple.
  assign prod      = quo * b0;
  assign slot_free = !rsp_valid || !rsp_stall;
  assign pop       = (state == IDLE) && !empty;

  // Sequencer with the response register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      rsp_valid <= 1'b0;
    end else begin
      // The response valid rises when a result is written and falls once it is taken.
      if ((state == WRITE) && slot_free) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (!empty) begin
            ok  <= pop_data[2*MW];
            a   <= pop_data[2*MW-1:MW];
            b   <= pop_data[MW-1:0];
            b0  <= pop_data[MW-1:0];
            k   <= '0;
            if (pop_data[2*MW]) begin
              quo   <= pop_data[2*MW-1:MW];
              state <= GCD;
            end else begin
              g     <= '0;
              quo   <= '0;
              state <= WRITE;
            end
          end
        end
        GCD: begin
          // One binary GCD step: strip common twos, odd twos, or subtract; equal operands end the loop.
          if (!a[0] && !b[0]) begin
            a <= a >> 1;
            b <= b >> 1;
            k <= k + 1'b1;
          end else if (!a[0]) begin
            a <= a >> 1;
          end else if (!b[0]) begin
            b <= b >> 1;
          end else if (a == b) begin
            g     <= a << k;
            rem   <= '0;
            cnt   <= '0;
            state <= DIV;
          end else if (a > b) begin
            a <= a - b;
          end else begin
            b <= b - a;
          end
        end
        DIV: begin
          rem <= fits ? MW'(trial - {1'b0, g}) : trial[MW-1:0];
          quo <= {quo[MW-2:0], fits};
          cnt <= cnt + 1'b1;
          if (cnt == KW'(MW - 1)) begin
            state <= WRITE;
          end
        end
        WRITE: begin
          if (slot_free) begin
            rsp.valid_res <= ok;
            rsp.divisor   <= DIVISOR_W'(g);
            rsp.multiple  <= MULTIPLE_W'(prod);
            state         <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: rtl/gcd_and_lcm.sv
// Top level of the GCD and LCM unit: front end, queue and arithmetic core.
// Each item pops from the queue in IDLE; one with a non-positive operand goes
// straight to WRITE, otherwise the core runs the binary GCD loop, then the
// bit-serial restoring division, then the multiply in WRITE.
// Throughput: one item at a time in the core, set by the GCD loop and the
// one-bit-per-cycle divider; a two-entry queue takes items meanwhile.
// Reset (rst, synchronous) empties the queue and clears the response valid.
`timescale 1ns / 1ps
`default_nettype none

module gcd_and_lcm import gal_pkg::*; #(
  parameter int OPERAND_WIDTH = 32
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     req_valid,
  output logic          req_stall,
  input  wire gal_req_t req,
  output logic          rsp_valid,
  input  wire logic     rsp_stall,
  output gal_rsp_t      rsp
);

  localparam int QW = 2 * OPERAND_WIDTH - 1;

  logic          push;
  logic [QW-1:0] push_data;
  logic          full;
  logic          pop;
  logic [QW-1:0] pop_data;
  logic          empty;

  // Operand extraction and classification.
  gal_front #(
    .OPERAND_WIDTH (OPERAND_WIDTH)
  ) u_front (
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .full      (full),
    .push      (push),
    .push_data (push_data)
  );

  // Queue between the front end and the core.
  gal_fifo #(
    .WIDTH (QW),
    .DEPTH (2)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (empty)
  );

  // GCD, division and multiply.
  gal_core #(
    .OPERAND_WIDTH (OPERAND_WIDTH)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .pop_data  (pop_data),
    .empty     (empty),
    .pop       (pop),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule

`default_nettype wire
